// ----- hdl/mrfd_pkg.sv -----
// Shared types and constants for the mesh repeater forwarding block.
`timescale 1ns / 1ps

package mrfd_pkg;

	// Result action codes.
	localparam logic [2:0] ACT_IGNORED   = 3'd0;
	localparam logic [2:0] ACT_DUP       = 3'd1;
	localparam logic [2:0] ACT_FORWARD   = 3'd2;
	localparam logic [2:0] ACT_PONG      = 3'd3;
	localparam logic [2:0] ACT_PONG_SEEN = 3'd4;
	localparam logic [2:0] ACT_PING_DUP  = 3'd5;
	localparam logic [2:0] ACT_RX_ERR    = 3'd6;

	// Payload kind codes; any other code is an ordinary packet.
	localparam logic [1:0] KIND_PING = 2'd1;
	localparam logic [1:0] KIND_PONG = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_OWN_NODE     = 2'd0;
	localparam logic [1:0] CFG_ADMIN_NODE   = 2'd1;
	localparam logic [1:0] CFG_CLIMBER_NODE = 2'd2;
	localparam logic [1:0] CFG_REPLY_HOPS   = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] RST_OWN_NODE     = 8'd2;
	localparam logic [7:0] RST_ADMIN_NODE   = 8'd1;
	localparam logic [7:0] RST_CLIMBER_NODE = 8'd3;
	localparam logic [7:0] RST_REPLY_HOPS   = 8'd3;

	typedef struct packed {
		logic [7:0] own_node;
		logic [7:0] admin_node;
		logic [7:0] climber_node;
		logic [7:0] reply_hops;
	} cfg_t;

	typedef struct packed {
		logic        rx_ok;
		logic [7:0]  pkt_src;
		logic [7:0]  pkt_dst;
		logic [7:0]  pkt_hops;
		logic [31:0] pkt_id;
		logic [1:0]  pkt_kind;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  out_src;
		logic [7:0]  out_dst;
		logic [7:0]  out_hops;
		logic [31:0] out_id;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DRAIN,
		ST_RESOLVE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic lookup;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_skip;
		logic last_read;
	} ctrl_sts_t;

endpackage

// ----- hdl/mrfd_cfg.sv -----
// Configuration register file for the mesh repeater forwarding block.
`timescale 1ns / 1ps

module mrfd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [7:0]        cfg_wdata,
	output mrfd_pkg::cfg_t    cfg
);

	mrfd_pkg::cfg_t cfg_q;

	// Register writes, one register per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node     <= mrfd_pkg::RST_OWN_NODE;
			cfg_q.admin_node   <= mrfd_pkg::RST_ADMIN_NODE;
			cfg_q.climber_node <= mrfd_pkg::RST_CLIMBER_NODE;
			cfg_q.reply_hops   <= mrfd_pkg::RST_REPLY_HOPS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mrfd_pkg::CFG_OWN_NODE:     cfg_q.own_node     <= cfg_wdata;
				mrfd_pkg::CFG_ADMIN_NODE:   cfg_q.admin_node   <= cfg_wdata;
				mrfd_pkg::CFG_CLIMBER_NODE: cfg_q.climber_node <= cfg_wdata;
				mrfd_pkg::CFG_REPLY_HOPS:   cfg_q.reply_hops   <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/mrfd_datapath.sv -----
// Datapath: captured header, id ring memory, sequential search and result register.
`timescale 1ns / 1ps

module mrfd_datapath #(
	parameter int CACHE_DEPTH = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mrfd_pkg::in_word_t     in_word,
	input  mrfd_pkg::cfg_t         cfg,
	input  mrfd_pkg::ctrl_cmd_t    cmd,
	output mrfd_pkg::ctrl_sts_t    sts,
	output mrfd_pkg::out_word_t    out_word
);

	localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_DEPTH - 1);

	mrfd_pkg::in_word_t  in_q;
	mrfd_pkg::out_word_t out_q;
	mrfd_pkg::out_word_t res;

	logic [31:0]            mem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] vld_q;
	logic [AW-1:0]          rd_idx_q;
	logic [AW-1:0]          wr_slot_q;
	logic [31:0]            rd_data_s1;
	logic                   rd_vld_s1;
	logic                   cmp_en_s1;
	logic                   hit_q;
	logic [31:0]            entry;
	logic                   record;
	logic                   fwd;

	// Capture the accepted header.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_word;
		end
	end

	// Ring memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.emit && record) begin
			mem[wr_slot_q] <= in_q.pkt_id;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	// An entry never written reads as zero.
	assign entry = rd_vld_s1 ? rd_data_s1 : 32'd0;

	// Search pointer, compare stage, hit flag, ring write slot and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_idx_q  <= '0;
			wr_slot_q <= '0;
			rd_vld_s1 <= 1'b0;
			cmp_en_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[rd_idx_q];
			cmp_en_s1 <= cmd.lookup;
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end else begin
				if (cmd.lookup && (rd_idx_q != LAST_IDX)) begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
				if (cmp_en_s1 && (entry == in_q.pkt_id)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.emit && record) begin
				vld_q[wr_slot_q] <= 1'b1;
				wr_slot_q <= (wr_slot_q == LAST_IDX) ? '0 : wr_slot_q + AW'(1);
			end
		end
	end

	// Directed admin/climber traffic or a broadcast from another node with hops left.
	assign fwd = ((in_q.pkt_src == cfg.admin_node) && (in_q.pkt_dst == cfg.climber_node)) ||
		((in_q.pkt_src == cfg.climber_node) && (in_q.pkt_dst == cfg.admin_node)) ||
		((in_q.pkt_dst == 8'd0) && (in_q.pkt_hops != 8'd0) &&
		(in_q.pkt_src != cfg.own_node));

	// Decide the result once the search is complete.
	always_comb begin
		res    = '0;
		record = 1'b0;
		if (!in_q.rx_ok) begin
			res.action = mrfd_pkg::ACT_RX_ERR;
		end else if (in_q.pkt_kind == mrfd_pkg::KIND_PING) begin
			if (hit_q) begin
				res.action = mrfd_pkg::ACT_PING_DUP;
			end else begin
				record       = 1'b1;
				res.action   = mrfd_pkg::ACT_PONG;
				res.out_src  = cfg.own_node;
				res.out_dst  = in_q.pkt_src;
				res.out_hops = cfg.reply_hops;
				res.out_id   = in_q.now_ms;
			end
		end else if (in_q.pkt_kind == mrfd_pkg::KIND_PONG) begin
			res.action = mrfd_pkg::ACT_PONG_SEEN;
		end else if (hit_q) begin
			res.action = mrfd_pkg::ACT_DUP;
		end else begin
			record = 1'b1;
			if (fwd) begin
				res.action   = mrfd_pkg::ACT_FORWARD;
				res.out_src  = in_q.pkt_src;
				res.out_dst  = in_q.pkt_dst;
				res.out_hops = in_q.pkt_hops - 8'd1;
				res.out_id   = in_q.pkt_id;
			end else begin
				res.action = mrfd_pkg::ACT_IGNORED;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_word      = out_q;
	assign sts.in_skip   = !in_word.rx_ok || (in_word.pkt_kind == mrfd_pkg::KIND_PONG);
	assign sts.last_read = (rd_idx_q == LAST_IDX);

	// The ring pointers never leave the cache.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_slot_q <= LAST_IDX)
		else $error("write slot beyond cache depth");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= LAST_IDX)
		else $error("read index beyond cache depth");

	// Every new word starts its search with the hit flag clear.
	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !hit_q)
		else $error("hit flag not cleared for a new word");

endmodule

// ----- hdl/mrfd_ctrl.sv -----
// Controller state machine: handshakes, search sequencing and result hand-off.
`timescale 1ns / 1ps

module mrfd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mrfd_pkg::ctrl_cmd_t    cmd,
	input  mrfd_pkg::ctrl_sts_t    sts
);

	mrfd_pkg::state_t state_q;
	mrfd_pkg::state_t state_d;
	logic             out_vld_q;
	logic             out_free;

	assign out_free = !out_vld_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrfd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.in_skip ? mrfd_pkg::ST_RESOLVE : mrfd_pkg::ST_LOOKUP;
				end
			end
			mrfd_pkg::ST_LOOKUP: begin
				if (sts.last_read) begin
					state_d = mrfd_pkg::ST_DRAIN;
				end
			end
			mrfd_pkg::ST_DRAIN: begin
				state_d = mrfd_pkg::ST_RESOLVE;
			end
			mrfd_pkg::ST_RESOLVE: begin
				if (out_free) begin
					state_d = mrfd_pkg::ST_IDLE;
				end
			end
			default: state_d = mrfd_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			mrfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mrfd_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			mrfd_pkg::ST_DRAIN: begin
			end
			mrfd_pkg::ST_RESOLVE: begin
				cmd.emit = out_free;
			end
			default: begin
			end
		endcase
	end

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mrfd_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= cmd.emit || (out_vld_q && !out_ready);
		end
	end

	assign out_valid = out_vld_q;

	// A result is only written when the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || out_ready))
		else $error("result written over a pending word");

	// An emitted result shows up as valid in the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");

	// An accepted word always starts processing.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != mrfd_pkg::ST_IDLE))
		else $error("accepted word not processed");

endmodule

// ----- hdl/mesh_repeater_forward_dedup.sv -----
// Top level of the mesh repeater forwarding step with duplicate id cache.
//
//   port group     dir   protocol     payload
//   in_*           in    valid/ready  in_word  (mrfd_pkg::in_word_t)
//   out_*          out   valid/ready  out_word (mrfd_pkg::out_word_t)
//   cfg_*          in    write only   cfg_idx, cfg_wdata (8 bit)
//
// A searched word (ordinary or PING) passes from accept through the LOOKUP, DRAIN and RESOLVE
// states: one cache entry is read per cycle through the single read port of the ring memory.
// Receive errors and PONG words skip the search and go from accept straight to RESOLVE.
// The next word is taken in the cycle after a result is written, even while that result waits;
// it stalls before writing its own result until the output register has been taken.
// Reset restores the configuration defaults and clears the per-entry valid bits.
`timescale 1ns / 1ps

module mesh_repeater_forward_dedup #(
	parameter int CACHE_DEPTH = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mrfd_pkg::in_word_t     in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mrfd_pkg::out_word_t    out_word,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_idx,
	input  logic [7:0]             cfg_wdata
);

	mrfd_pkg::cfg_t      cfg;
	mrfd_pkg::ctrl_cmd_t cmd;
	mrfd_pkg::ctrl_sts_t sts;

	mrfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mrfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mrfd_datapath #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);

endmodule
